>>> rtl/srrc_pkg.sv
`default_nettype none
package srrc_pkg;

  localparam int DataW = 32;
  localparam int OfsW  = 8;
  localparam int PortW = 2;

  // Register byte offsets
  localparam logic [OfsW-1:0] OFS_AGGREGATE = 8'h00;
  localparam logic [OfsW-1:0] OFS_ID        = 8'h04;
  localparam logic [OfsW-1:0] OFS_CONTROL   = 8'h08;
  localparam logic [OfsW-1:0] OFS_STATUS    = 8'h0C;

  // Beat kinds
  localparam logic ACT_BUS  = 1'b0;
  localparam logic ACT_RESP = 1'b1;

  // Highest id usable as a direct port select
  localparam logic [DataW-1:0] DIRECT_ID_MAX = 32'd3;
  localparam logic [DataW-1:0] AGGR_DIRECT   = 32'd1;

  typedef struct packed {
    logic             action;
    logic             write;
    logic [OfsW-1:0]  reg_offset;
    logic [DataW-1:0] write_data;
    logic [PortW-1:0] resp_port;
    logic             resp_wake;
    logic             resp_error;
  } cmd_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             access_fault;
    logic             request_valid;
    logic [PortW-1:0] request_port;
    logic [DataW-1:0] request_aggregate;
    logic [DataW-1:0] request_target;
    logic             done_interrupt;
  } rsp_t;

endpackage
`default_nettype wire

>>> rtl/sync_request_register_controller_core.sv
`default_nettype none
// Sync request register controller.
// Command channel (cmd_valid / cmd_stall / cmd): one beat is either a bus
// access to the aggregate (0x00), id (0x04), control (0x08) or status (0x0C)
// register, or a response arriving from one of the four sync ports.
// Result channel (rsp_valid / rsp_stall / rsp): exactly one beat per command,
// in order, carrying read data, fault, any issued sync request and the
// completion interrupt pulse.
// Pipeline: a command passes through the input register, then the result
// register. Throughput: one command per cycle while the receiver does not
// stall; the controller state updates in the single cycle the beat moves
// from the input register into the result register.
// Reset (rst, synchronous): aggregate, id and status flags clear, both
// pipeline registers empty.
// Receiver stall: the result register holds; the input register keeps
// accepting until it is also full, from then cmd_stall follows rsp_stall
// in the same cycle.
module sync_request_register_controller_core (
  input  wire            clk,
  input  wire            rst,
  input  wire            cmd_valid,
  output logic           cmd_stall,
  input  srrc_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  wire            rsp_stall,
  output srrc_pkg::rsp_t rsp
);
  import srrc_pkg::*;

  logic  s1_valid;
  cmd_t  s1_cmd;
  rsp_t  s1_res;
  logic  out_free;
  logic  adv;

  // beat moves on when the result register has room
  assign adv       = s1_valid && out_free;
  assign cmd_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!cmd_stall) begin
      s1_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      s1_cmd <= cmd;
    end
  end

  srrc_regfile u_regfile (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .item (s1_cmd),
    .res  (s1_res)
  );

  srrc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_valid),
    .res       (s1_res),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .free      (out_free)
  );

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid && $stable(s1_cmd))
    else $error("input register lost a beat");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (rst)
    adv |=> rsp_valid)
    else $error("advanced beat missing at output");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> s1_valid && rsp_valid && rsp_stall)
    else $error("stall without full pipeline");

endmodule
`default_nettype wire

>>> rtl/srrc_regfile.sv
`default_nettype none
module srrc_regfile (
  input  wire            clk,
  input  wire            rst,
  input  wire            adv,
  input  srrc_pkg::cmd_t item,
  output srrc_pkg::rsp_t res
);
  import srrc_pkg::*;

  logic [DataW-1:0] aggregate_word, aggregate_word_next;
  logic [DataW-1:0] target_word, target_word_next;
  logic             busy, busy_next;
  logic             error_flag, error_flag_next;
  logic             done, done_next;
  logic             direct;
  logic             dir_ok;
  logic [PortW-1:0] port_sel;

  assign direct   = (aggregate_word == AGGR_DIRECT);
  assign dir_ok   = !direct || (target_word <= DIRECT_ID_MAX);
  assign port_sel = direct ? target_word[PortW-1:0] : {1'b0, target_word[0]};

  always_comb begin
    aggregate_word_next = aggregate_word;
    target_word_next    = target_word;
    busy_next           = busy;
    error_flag_next     = error_flag;
    done_next           = done;
    res                 = '0;
    if (item.action == ACT_RESP) begin
      if (item.resp_error) begin
        busy_next       = 1'b0;
        error_flag_next = 1'b1;
        done_next       = 1'b1;
      end else if (item.resp_wake) begin
        busy_next          = 1'b0;
        error_flag_next    = 1'b0;
        done_next          = 1'b1;
        res.done_interrupt = 1'b1;
      end
    end else begin
      case (item.reg_offset)
        OFS_AGGREGATE: begin
          if (!item.write) res.read_data = aggregate_word;
          else if (!busy) aggregate_word_next = item.write_data;
        end
        OFS_ID: begin
          if (!item.write) res.read_data = target_word;
          else if (!busy) target_word_next = item.write_data;
        end
        OFS_CONTROL: begin
          // writes while busy are dropped silently
          if (item.write && !busy) begin
            if (dir_ok) begin
              res.request_valid     = 1'b1;
              res.request_port      = port_sel;
              res.request_aggregate = aggregate_word;
              res.request_target    = target_word;
              busy_next             = 1'b1;
              error_flag_next       = 1'b0;
              done_next             = 1'b0;
            end else begin
              res.access_fault = 1'b1;
            end
          end
        end
        OFS_STATUS: begin
          if (item.write) res.access_fault = 1'b1;
          else res.read_data = {{(DataW-3){1'b0}}, busy, error_flag, done};
        end
        default: begin
          res.access_fault = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      aggregate_word <= '0;
      target_word    <= '0;
      busy           <= 1'b0;
      error_flag     <= 1'b0;
      done           <= 1'b0;
    end else if (adv) begin
      aggregate_word <= aggregate_word_next;
      target_word    <= target_word_next;
      busy           <= busy_next;
      error_flag     <= error_flag_next;
      done           <= done_next;
    end
  end

  a_req_sets_busy: assert property (@(posedge clk) disable iff (rst)
    adv && res.request_valid |=> busy && !done && !error_flag)
    else $error("request did not set busy");

  a_wake_done: assert property (@(posedge clk) disable iff (rst)
    adv && res.done_interrupt |=> !busy && done && !error_flag)
    else $error("wake did not complete request");

  a_req_only_idle: assert property (@(posedge clk) disable iff (rst)
    res.request_valid |-> !busy && !res.access_fault)
    else $error("request issued while busy or with fault");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(aggregate_word) && $stable(target_word) && $stable(busy))
    else $error("state changed without an item");

endmodule
`default_nettype wire

>>> rtl/srrc_out_reg.sv
`default_nettype none
module srrc_out_reg (
  input  wire            clk,
  input  wire            rst,
  input  wire            load,
  input  srrc_pkg::rsp_t res,
  input  wire            rsp_stall,
  output logic           rsp_valid,
  output srrc_pkg::rsp_t rsp,
  output logic           free
);
  import srrc_pkg::*;

  // register can take a new beat when empty or being drained
  assign free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (free) begin
      rsp_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      rsp <= res;
    end
  end

endmodule
`default_nettype wire

>>> dv/sync_request_register_controller_core_test.sv
module sync_request_register_controller_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import srrc_pkg::*;

  // Cycles with no beat moving on either channel before the run is declared hung.
  // This is well above the receiver hold and any plausible random gap.
  localparam int unsigned QUIET_LIMIT = 2000;
  // Length of the deliberate receiver hold in the backpressure test
  localparam int unsigned HOLD_CYCLES = 60;
  // Cycles allowed after the last result for stray beats (two-stage pipeline)
  localparam int unsigned DRAIN_CYCLES = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  sync_request_register_controller_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // Shadow copy of the controller's registers and status flags
  logic [DataW-1:0] shadow_aggregate = '0;
  logic [DataW-1:0] shadow_target = '0;
  logic shadow_busy = 1'b0;
  logic shadow_error = 1'b0;
  logic shadow_done = 1'b0;

  // Result beats owed by the block, oldest first
  rsp_t awaited_rsp[$];

  int unsigned mismatch_count = 0;
  int unsigned beats_sent = 0;
  int unsigned idle_pct = 0;   // chance per cycle that the sender holds back
  int unsigned stall_pct = 0;  // chance per cycle that the receiver stalls
  logic hold_request = 1'b0;   // asks the receiver process for a long hold
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the controller: computes the one result beat owed for a command
  // beat and moves the shadow state along, in acceptance order.
  // ---------------------------------------------------------------------------
  function automatic rsp_t apply_beat(input cmd_t c);
    rsp_t r;
    r = '0;
    if (c.action == ACT_RESP) begin
      // Error wins over wake; a beat with neither leaves everything alone.
      // The port field never matters, and a response while idle still lands.
      if (c.resp_error) begin
        shadow_busy = 1'b0;
        shadow_error = 1'b1;
        shadow_done = 1'b1;
      end else if (c.resp_wake) begin
        shadow_busy = 1'b0;
        shadow_error = 1'b0;
        shadow_done = 1'b1;
        r.done_interrupt = 1'b1;
      end
    end else begin
      case (c.reg_offset)
        OFS_AGGREGATE: begin
          if (!c.write) r.read_data = shadow_aggregate;
          else if (!shadow_busy) shadow_aggregate = c.write_data;
        end
        OFS_ID: begin
          if (!c.write) r.read_data = shadow_target;
          else if (!shadow_busy) shadow_target = c.write_data;
        end
        OFS_CONTROL: begin
          // Reads return zero; triggers while busy are dropped without a fault
          if (c.write && !shadow_busy) begin
            if (shadow_aggregate == AGGR_DIRECT && shadow_target > DIRECT_ID_MAX) begin
              // direct select with no such port
              r.access_fault = 1'b1;
            end else begin
              r.request_valid = 1'b1;
              r.request_port = (shadow_aggregate == AGGR_DIRECT) ?
                               shadow_target[PortW-1:0] : {1'b0, shadow_target[0]};
              r.request_aggregate = shadow_aggregate;
              r.request_target = shadow_target;
              shadow_busy = 1'b1;
              shadow_error = 1'b0;
              shadow_done = 1'b0;
            end
          end
        end
        OFS_STATUS: begin
          if (c.write) r.access_fault = 1'b1;
          else r.read_data = {{(DataW-3){1'b0}}, shadow_busy, shadow_error, shadow_done};
        end
        default: r.access_fault = 1'b1;
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Beat builders. Fields a beat does not use are filled with noise so that
  // the block is seen to ignore them.
  // ---------------------------------------------------------------------------
  function automatic cmd_t random_fill();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[$bits(cmd_t)-1:0];
  endfunction

  function automatic logic [OfsW-1:0] any_register();
    case ($urandom_range(3))
      0: return OFS_AGGREGATE;
      1: return OFS_ID;
      2: return OFS_CONTROL;
      default: return OFS_STATUS;
    endcase
  endfunction

  function automatic cmd_t bus_beat(input logic wr, input logic [OfsW-1:0] ofs,
                                    input logic [DataW-1:0] data);
    cmd_t c;
    c = random_fill();
    c.action = ACT_BUS;
    c.write = wr;
    c.reg_offset = ofs;
    c.write_data = data;
    return c;
  endfunction

  function automatic cmd_t port_beat(input logic [PortW-1:0] port, input logic wake,
                                     input logic err);
    cmd_t c;
    c = random_fill();
    c.action = ACT_RESP;
    c.resp_port = port;
    c.resp_wake = wake;
    c.resp_error = err;
    return c;
  endfunction

  // Anything at all, half the time aimed at a real register
  function automatic cmd_t noise_beat();
    cmd_t c;
    c = random_fill();
    if ($urandom_range(1)) c.reg_offset = any_register();
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: optional random gap, then hold the beat until it is taken.
  // Called at a falling edge and returns at a falling edge, with valid left
  // high so back-to-back beats follow without a gap.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input cmd_t beat);
    while ($urandom_range(99) < idle_pct) begin
      cmd_valid = 1'b0;
      @(negedge clk);
    end
    cmd = beat;
    cmd_valid = 1'b1;
    @(posedge clk);
    while (cmd_stall !== 1'b0) @(posedge clk);
    awaited_rsp.push_back(apply_beat(beat));
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [DataW-1:0] got,
                             input logic [DataW-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Result side: receiver stall pattern, with an optional long hold, driven at
  // the falling edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      rsp_stall = 1'b1;
      hold_left--;
    end else begin
      rsp_stall = ($urandom_range(99) < stall_pct);
    end
  end

  // Every result beat taken is matched against the oldest owed one
  always @(posedge clk) begin : result_check
    rsp_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (awaited_rsp.size() == 0) begin
        report_mismatch("result beat with nothing outstanding");
      end else begin
        want = awaited_rsp.pop_front();
        check_field("read_data", rsp.read_data, want.read_data);
        check_field("access_fault", 32'(rsp.access_fault), 32'(want.access_fault));
        check_field("request_valid", 32'(rsp.request_valid), 32'(want.request_valid));
        check_field("request_port", 32'(rsp.request_port), 32'(want.request_port));
        check_field("request_aggregate", rsp.request_aggregate, want.request_aggregate);
        check_field("request_target", rsp.request_target, want.request_target);
        check_field("done_interrupt", 32'(rsp.done_interrupt), 32'(want.done_interrupt));
      end
    end
  end

  // Hang detector: too long with no beat moving on either channel
  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((cmd_valid && cmd_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("timeout: no beat moved in %0d cycles", QUIET_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // All registers read back zero out of reset, control included
  task automatic test_reset_state();
    send_beat(bus_beat(1'b0, OFS_AGGREGATE, '1));
    send_beat(bus_beat(1'b0, OFS_ID, '1));
    send_beat(bus_beat(1'b0, OFS_CONTROL, '1));
    send_beat(bus_beat(1'b0, OFS_STATUS, '1));
  endtask

  // Aggregate other than one: id parity picks port 0/1. Ends with an error
  // response, so status shows done and error.
  task automatic test_parity_trigger();
    send_beat(bus_beat(1'b1, OFS_AGGREGATE, '1));
    send_beat(bus_beat(1'b1, OFS_ID, '1));
    send_beat(bus_beat(1'b1, OFS_CONTROL, '0));
    send_beat(port_beat(2'd0, 1'b0, 1'b1));
  endtask

  // Aggregate one: id picks the port directly. Writes while busy are dropped;
  // a wake finishes the request and fires the interrupt; a response with
  // neither flag afterwards changes nothing.
  task automatic test_direct_trigger_wake();
    send_beat(bus_beat(1'b1, OFS_AGGREGATE, AGGR_DIRECT));
    send_beat(bus_beat(1'b1, OFS_ID, DIRECT_ID_MAX));
    send_beat(bus_beat(1'b1, OFS_CONTROL, '1));
    send_beat(bus_beat(1'b1, OFS_ID, '0));
    send_beat(bus_beat(1'b0, OFS_ID, '0));
    send_beat(bus_beat(1'b0, OFS_STATUS, '0));
    send_beat(port_beat(2'd3, 1'b1, 1'b0));
    send_beat(port_beat(2'd1, 1'b0, 1'b0));
    send_beat(bus_beat(1'b0, OFS_STATUS, '0));
  endtask

  // Direct select of a nonexistent port, status write, unknown offsets
  task automatic test_access_faults();
    send_beat(bus_beat(1'b1, OFS_ID, DIRECT_ID_MAX + 1));
    send_beat(bus_beat(1'b1, OFS_CONTROL, '0));
    send_beat(bus_beat(1'b1, OFS_STATUS, '1));
    send_beat(bus_beat(1'b0, 8'hFF, '0));
    send_beat(bus_beat(1'b1, 8'h01, '1));
  endtask

  // Typical driver sequence: set up, trigger, maybe poke while busy,
  // usually a port response, maybe poll status. Steps are skipped at random.
  task automatic send_sync_sequence();
    logic [DataW-1:0] aggr;
    logic [DataW-1:0] id;
    int unsigned roll;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: aggr = AGGR_DIRECT;
      5: aggr = '0;
      6: aggr = '1;
      default: aggr = $urandom;
    endcase
    if (aggr == AGGR_DIRECT && $urandom_range(7) != 0) id = $urandom_range(3);
    else if ($urandom_range(1)) id = $urandom;
    else id = $urandom_range(7);
    if ($urandom_range(3) != 0) send_beat(bus_beat(1'b1, OFS_AGGREGATE, aggr));
    if ($urandom_range(3) != 0) send_beat(bus_beat(1'b1, OFS_ID, id));
    send_beat(bus_beat(1'b1, OFS_CONTROL, $urandom));
    if ($urandom_range(2) == 0)
      send_beat(bus_beat(1'($urandom_range(1)), any_register(), $urandom));
    if ($urandom_range(5) != 0) begin
      roll = $urandom_range(19);
      if (roll < 12)
        send_beat(port_beat(2'($urandom_range(3)), 1'b1, 1'b0));
      else if (roll < 17)
        send_beat(port_beat(2'($urandom_range(3)), 1'($urandom_range(1)), 1'b1));
      else
        send_beat(port_beat(2'($urandom_range(3)), 1'b0, 1'b0));
    end
    if ($urandom_range(1)) send_beat(bus_beat(1'b0, OFS_STATUS, $urandom));
  endtask

  // Receiver holds off for a long stretch while the sender keeps pushing,
  // so the pipeline fills and cmd_stall must rise
  task automatic test_backpressure();
    int unsigned stop_at;
    idle_pct = 0;
    stall_pct = 0;
    hold_request = 1'b1;
    stop_at = beats_sent + 24;
    while (beats_sent < stop_at) send_sync_sequence();
  endtask

  task automatic test_random_traffic(input int unsigned sender_idle,
                                     input int unsigned receiver_stall,
                                     input int unsigned beats);
    int unsigned stop_at;
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) begin
      if ($urandom_range(9) < 7) send_sync_sequence();
      else send_beat(noise_beat());
    end
  endtask

  initial begin : main
    repeat (10) @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_parity_trigger();
    test_direct_trigger_wake();
    test_access_faults();
    test_backpressure();
    test_random_traffic(0, 0, 465);
    test_random_traffic(84, 0, 465);
    test_random_traffic(0, 84, 465);
    test_random_traffic(23, 23, 465);

    // Stop offering, let everything owed come back, then watch for strays
    cmd_valid = 1'b0;
    stall_pct = 0;
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/srrc_pkg.sv
rtl/srrc_regfile.sv
rtl/srrc_out_reg.sv
rtl/sync_request_register_controller_core.sv
dv/sync_request_register_controller_core_test.sv
